// ===== src/rds_pkg.sv =====
package rds_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int LINE_LENGTH = 1024;
    localparam int SHAPE_COUNT = 9;
    localparam int NAME_MAX    = 8;

    localparam int POS_W  = $clog2(LINE_LENGTH + 1);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int KPOS_W = $clog2(NAME_MAX);

    typedef enum logic [2:0] {
        ST_OK,
        ST_UNKNOWN,
        ST_AMBIGUOUS,
        ST_MISSING,
        ST_SEPARATION
    } status_t;

    typedef enum logic [1:0] {
        CONN_NONE,
        CONN_AND,
        CONN_OR
    } conn_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef logic [SHAPE_COUNT-1:0] shape_mask_t;
    typedef logic [NAME_MAX*8-1:0]  name_t;

    // names are left aligned, first letter in the top byte, padded with nul
    localparam name_t SHAPE_NAMES [SHAPE_COUNT] = '{
        {"ANNULUS", 8'h00},
        {"ARROW",   24'h0},
        {"BOX",     40'h0},
        {"CIRCLE",  16'h0},
        {"ELLIPSE", 8'h00},
        {"PIE",     40'h0},
        {"POINT",   24'h0},
        {"POLYGON", 8'h00},
        {"TEXT",    32'h0}
    };

    typedef struct packed {
        logic       none;
        logic       many;
        logic [3:0] shape;
    } close_info_t;

    typedef struct packed {
        logic             kind;
        logic [3:0]       region_index;
        logic [3:0]       region_type;
        logic             exclude_flag;
        logic             negate_flag;
        conn_t            connector;
        logic [POS_W-1:0] param_start;
        status_t          status;
        logic [3:0]       region_count;
    } rds_result_t;

endpackage

// ===== src/rds_name_match.sv =====
module rds_name_match
(
    input  logic [7:0]            ch,
    input  logic [3:0]            name_len,
    input  rds_pkg::shape_mask_t  mask_in,
    output rds_pkg::shape_mask_t  mask_out,
    output rds_pkg::close_info_t  close_info
);

    logic [7:0]                 c_up;
    logic [rds_pkg::KPOS_W-1:0] kpos;
    logic                       in_range;

    assign c_up     = (ch >= 8'h61 && ch <= 8'h7A) ? (ch - 8'd32) : ch;
    assign kpos     = name_len[rds_pkg::KPOS_W-1:0];
    assign in_range = ({1'b0, name_len} < 5'(rds_pkg::NAME_MAX));

    always_comb
    begin
        logic [7:0] sel;
        for (int s = 0; s < rds_pkg::SHAPE_COUNT; s++)
        begin
            sel = rds_pkg::SHAPE_NAMES[s][(rds_pkg::NAME_MAX - 1 - int'(kpos)) * 8 +: 8];
            mask_out[s] = mask_in[s] && in_range && (sel != 8'h00) && (sel == c_up);
        end
    end

    // lowest surviving candidate wins when exactly one is left
    always_comb
    begin
        close_info.none  = (mask_in == '0);
        close_info.many  = ((mask_in & (mask_in - 1'b1)) != '0);
        close_info.shape = '0;
        for (int s = rds_pkg::SHAPE_COUNT - 1; s >= 0; s--)
        begin
            if (mask_in[s])
            begin
                close_info.shape = 4'(s);
            end
        end
    end

endmodule

// ===== src/rds_scanner.sv =====
module rds_scanner
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           ch,
    input  logic                 end_of_line,
    output logic                 res_valid,
    output rds_pkg::rds_result_t res
);

    typedef enum logic [1:0] {
        PH_FRESH,
        PH_MUST,
        PH_NAME,
        PH_FOUND
    } phase_t;

    phase_t                     phase_reg,   phase_next;
    rds_pkg::shape_mask_t       mask_reg,    mask_next;
    logic [3:0]                 len_reg,     len_next;
    logic [rds_pkg::POS_W-1:0]  pos_reg,     pos_next;
    logic [rds_pkg::CNT_W-1:0]  regions_reg, regions_next;
    logic                       excl_reg,    excl_next;
    logic                       neg_reg,     neg_next;
    rds_pkg::conn_t             conn_reg,    conn_next;
    rds_pkg::status_t           err_reg,     err_next;

    rds_pkg::shape_mask_t       match_mask_in;
    rds_pkg::shape_mask_t       match_mask_out;
    logic [3:0]                 match_len;
    rds_pkg::close_info_t       close_info;
    logic [rds_pkg::POS_W-1:0]  pos_inc;
    logic [rds_pkg::CNT_W-1:0]  regions_inc;

    // a fresh name starts from every shape at letter zero
    assign match_mask_in = (phase_reg == PH_NAME) ? mask_reg : '1;
    assign match_len     = (phase_reg == PH_NAME) ? len_reg : 4'd0;

    rds_name_match u_match
    (
        .ch         (ch),
        .name_len   (match_len),
        .mask_in    (match_mask_in),
        .mask_out   (match_mask_out),
        .close_info (close_info)
    );

    assign pos_inc     = (pos_reg < rds_pkg::POS_W'(rds_pkg::LINE_LENGTH))
                         ? (pos_reg + 1'b1) : pos_reg;
    assign regions_inc = regions_reg + 1'b1;

    always_comb
    begin
        rds_pkg::status_t st;
        phase_next   = phase_reg;
        mask_next    = mask_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        regions_next = regions_reg;
        excl_next    = excl_reg;
        neg_next     = neg_reg;
        conn_next    = conn_reg;
        err_next     = err_reg;
        res_valid    = 1'b0;
        res          = '0;
        st           = err_reg;

        if (end_of_line)
        begin
            if (err_reg == rds_pkg::ST_OK)
            begin
                if (phase_reg == PH_MUST)
                begin
                    st = rds_pkg::ST_SEPARATION;
                end
                else if (phase_reg == PH_NAME)
                begin
                    st = rds_pkg::ST_MISSING;
                end
            end
            res_valid        = 1'b1;
            res.kind         = 1'b1;
            res.status       = st;
            res.region_count = (st == rds_pkg::ST_OK) ? 4'(regions_reg) : 4'd0;
            // verdict closes the line, everything back to its reset value
            phase_next   = PH_FRESH;
            mask_next    = '1;
            len_next     = '0;
            pos_next     = '0;
            regions_next = '0;
            excl_next    = 1'b0;
            neg_next     = 1'b0;
            conn_next    = rds_pkg::CONN_NONE;
            err_next     = rds_pkg::ST_OK;
        end
        else
        begin
            pos_next = pos_inc;
            if (err_reg == rds_pkg::ST_OK)
            begin
                case (phase_reg)
                    PH_FRESH, PH_MUST:
                    begin
                        if (ch == rds_pkg::CH_MINUS)
                        begin
                            excl_next  = 1'b1;
                            phase_next = PH_MUST;
                        end
                        else if (ch == rds_pkg::CH_BANG)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_MUST;
                        end
                        else if (ch != rds_pkg::CH_SPACE)
                        begin
                            mask_next  = match_mask_out;
                            len_next   = 4'd1;
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        if (ch == rds_pkg::CH_SPACE)
                        begin
                            if (close_info.none)
                            begin
                                err_next = rds_pkg::ST_UNKNOWN;
                            end
                            else if (close_info.many)
                            begin
                                err_next = rds_pkg::ST_AMBIGUOUS;
                            end
                            else
                            begin
                                res_valid        = 1'b1;
                                res.region_index = 4'(regions_reg);
                                res.region_type  = close_info.shape;
                                res.exclude_flag = excl_reg;
                                res.negate_flag  = neg_reg;
                                res.connector    = conn_reg;
                                res.param_start  = pos_inc;
                                regions_next     = regions_inc;
                                excl_next        = 1'b0;
                                neg_next         = 1'b0;
                                conn_next        = rds_pkg::CONN_NONE;
                                phase_next       = PH_FOUND;
                                if (regions_inc >= rds_pkg::CNT_W'(rds_pkg::MAX_REGIONS))
                                begin
                                    err_next = rds_pkg::ST_SEPARATION;
                                end
                            end
                        end
                        else
                        begin
                            mask_next = match_mask_out;
                            len_next  = (len_reg < 4'd15) ? (len_reg + 1'b1) : len_reg;
                        end
                    end
                    PH_FOUND:
                    begin
                        if (ch == rds_pkg::CH_AMP)
                        begin
                            conn_next  = rds_pkg::CONN_AND;
                            phase_next = PH_MUST;
                        end
                        else if (ch == rds_pkg::CH_BAR)
                        begin
                            conn_next  = rds_pkg::CONN_OR;
                            phase_next = PH_MUST;
                        end
                        else if (ch == rds_pkg::CH_SEMI)
                        begin
                            phase_next = PH_FRESH;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FRESH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FRESH;
            mask_reg    <= '1;
            len_reg     <= '0;
            pos_reg     <= '0;
            regions_reg <= '0;
            excl_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            conn_reg    <= rds_pkg::CONN_NONE;
            err_reg     <= rds_pkg::ST_OK;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            regions_reg <= regions_next;
            excl_reg    <= excl_next;
            neg_reg     <= neg_next;
            conn_reg    <= conn_next;
            err_reg     <= err_next;
        end
    end

    a_found_has_region: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FOUND |-> regions_reg != '0)
        else $error("region found phase with no region counted");

    a_region_limit: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == rds_pkg::ST_OK |-> regions_reg < rds_pkg::CNT_W'(rds_pkg::MAX_REGIONS))
        else $error("region count reached the limit without an error");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && !end_of_line && err_reg != rds_pkg::ST_OK |-> !res_valid)
        else $error("record produced after an error latched");

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_line |=> phase_reg == PH_FRESH && regions_reg == '0
                                && pos_reg == '0 && err_reg == rds_pkg::ST_OK)
        else $error("line state not cleared after verdict");

endmodule

// ===== src/region_descriptor_splitter.sv =====
// region descriptor splitter
// input channel (in_valid/in_ready): one beat per character of a cleaned line
// whose separators are already spaces, followed by one beat with end_of_line
// set; ch is ignored on that beat.
// output channel (out_valid/out_ready): a region record (kind 0) at the space
// that closes a valid shape name, and one verdict beat (kind 1) per line with
// status and region_count. most characters produce no beat at all.
// path: an accepted beat lands in the input register and is scanned from there;
// its result goes through the output register to the output ports.
// throughput: one beat per cycle while no result waits on a stalled output;
// the scan is one pass of short logic between the input register and the output
// register, and line state feeds back in that same cycle.
// stalls: while out_ready is low a waiting result holds; the input register
// still takes one beat, a beat that produces nothing moves on regardless, and
// a beat with a result waits there, which drops in_ready.
// reset: scanner returns to a fresh seek with no regions, no pending flags
// and no error; both registers empty. the verdict beat restores the same
// state for the next line.
module region_descriptor_splitter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                ch,
    input  logic                      end_of_line,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      kind,
    output logic [3:0]                region_index,
    output logic [3:0]                region_type,
    output logic                      exclude_flag,
    output logic                      negate_flag,
    output logic [1:0]                connector,
    output logic [rds_pkg::POS_W-1:0] param_start,
    output logic [2:0]                status,
    output logic [3:0]                region_count
);

    logic                 stage_valid_reg, stage_valid_next;
    logic [7:0]           ch_reg;
    logic                 eol_reg;
    logic                 out_valid_reg,   out_valid_next;
    rds_pkg::rds_result_t res_reg;

    logic                 res_valid;
    rds_pkg::rds_result_t res;
    logic                 stage_fire;
    logic                 in_take;

    // a beat with no result may pass even while the output waits
    assign stage_fire = stage_valid_reg && (!res_valid || !out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_fire;
    assign in_take    = in_valid && in_ready;

    rds_scanner u_scanner
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (stage_fire),
        .ch          (ch_reg),
        .end_of_line (eol_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb
    begin
        stage_valid_next = in_take ? 1'b1 : (stage_fire ? 1'b0 : stage_valid_reg);
        if (stage_fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg  <= ch;
            eol_reg <= end_of_line;
        end
        if (stage_fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign region_index = res_reg.region_index;
    assign region_type  = res_reg.region_type;
    assign exclude_flag = res_reg.exclude_flag;
    assign negate_flag  = res_reg.negate_flag;
    assign connector    = res_reg.connector;
    assign param_start  = res_reg.param_start;
    assign status       = res_reg.status;
    assign region_count = res_reg.region_count;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SCAN_FRESH,
        SCAN_MUST,
        SCAN_NAME,
        SCAN_FOUND
    } scan_t;

    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [8:0] ALL_SHAPES = '1;
    localparam int RANDOM_ITEMS = 50;
    localparam int STEADY_ITEMS = 30;
    localparam int DRAIN_CYCLES = 10;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [7:0]                ch;
    logic                      end_of_line;
    logic                      out_valid;
    logic                      out_ready;
    logic                      kind;
    logic [3:0]                region_index;
    logic [3:0]                region_type;
    logic                      exclude_flag;
    logic                      negate_flag;
    logic [1:0]                connector;
    logic [rds_pkg::POS_W-1:0] param_start;
    logic [2:0]                status;
    logic [3:0]                region_count;

    string shape_txt [rds_pkg::SHAPE_COUNT] = '{"ANNULUS", "ARROW", "BOX", "CIRCLE",
                                                "ELLIPSE", "PIE", "POINT", "POLYGON",
                                                "TEXT"};
    int    unique_len [rds_pkg::SHAPE_COUNT] = '{2, 2, 1, 1, 1, 2, 3, 3, 1};

    // line scanner state mirrored in the testbench
    scan_t            ph;
    logic [8:0]       cand;
    logic [3:0]       name_len;
    logic [10:0]      pos;
    logic [4:0]       found;
    logic             excl_pend;
    logic             neg_pend;
    rds_pkg::conn_t   conn_pend;
    rds_pkg::status_t err;

    rds_pkg::rds_result_t beats_due [$];
    int                   errors = 0;
    int                   sent = 0;
    bit                   quiet = 1'b0;

    region_descriptor_splitter u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_line  (end_of_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .region_index (region_index),
        .region_type  (region_type),
        .exclude_flag (exclude_flag),
        .negate_flag  (negate_flag),
        .connector    (connector),
        .param_start  (param_start),
        .status       (status),
        .region_count (region_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_line_state();
        ph        = SCAN_FRESH;
        cand      = ALL_SHAPES;
        name_len  = '0;
        pos       = '0;
        found     = '0;
        excl_pend = 1'b0;
        neg_pend  = 1'b0;
        conn_pend = rds_pkg::CONN_NONE;
        err       = rds_pkg::ST_OK;
    endfunction

    function automatic void fold_name_char(input logic [7:0] c);
        logic [7:0] u;
        int k;
        u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - 8'd32 : c;
        k = int'(name_len);
        for (int i = 0; i < rds_pkg::SHAPE_COUNT; i++)
        begin
            if (!(k < shape_txt[i].len() && shape_txt[i][k] == u))
                cand[i] = 1'b0;
        end
        if (name_len < 4'd15)
            name_len++;
    endfunction

    // advance the line scanner by one beat and queue the result it causes
    function automatic void track_line_char(input logic [7:0] c, input logic eol);
        rds_pkg::rds_result_t r;
        rds_pkg::status_t st;
        int t;
        int ps;
        r = '0;
        if (eol)
        begin
            st = err;
            if (st == rds_pkg::ST_OK && ph == SCAN_MUST)
                st = rds_pkg::ST_SEPARATION;
            else if (st == rds_pkg::ST_OK && ph == SCAN_NAME)
                st = rds_pkg::ST_MISSING;
            r.kind = 1'b1;
            r.status = st;
            r.region_count = (st == rds_pkg::ST_OK) ? found[3:0] : 4'd0;
            beats_due.push_back(r);
            clear_line_state();
        end
        else
        begin
            if (err == rds_pkg::ST_OK)
            begin
                case (ph)
                    SCAN_FRESH, SCAN_MUST:
                    begin
                        if (c == rds_pkg::CH_MINUS)
                        begin
                            excl_pend = 1'b1;
                            ph = SCAN_MUST;
                        end
                        else if (c == rds_pkg::CH_BANG)
                        begin
                            neg_pend = 1'b1;
                            ph = SCAN_MUST;
                        end
                        else if (c != rds_pkg::CH_SPACE)
                        begin
                            cand = ALL_SHAPES;
                            name_len = '0;
                            fold_name_char(c);
                            ph = SCAN_NAME;
                        end
                    end
                    SCAN_NAME:
                    begin
                        if (c != rds_pkg::CH_SPACE)
                            fold_name_char(c);
                        else if (cand == '0)
                            err = rds_pkg::ST_UNKNOWN;
                        else if ((cand & (cand - 9'd1)) != '0)
                            err = rds_pkg::ST_AMBIGUOUS;
                        else
                        begin
                            t = 0;
                            while (!cand[t])
                                t++;
                            ps = int'(pos) + 1;
                            if (ps > rds_pkg::LINE_LENGTH)
                                ps = rds_pkg::LINE_LENGTH;
                            r.region_index = found[3:0];
                            r.region_type = 4'(t);
                            r.exclude_flag = excl_pend;
                            r.negate_flag = neg_pend;
                            r.connector = conn_pend;
                            r.param_start = rds_pkg::POS_W'(ps);
                            beats_due.push_back(r);
                            found++;
                            excl_pend = 1'b0;
                            neg_pend = 1'b0;
                            conn_pend = rds_pkg::CONN_NONE;
                            ph = SCAN_FOUND;
                            // the record that fills the table still goes out
                            if (found >= rds_pkg::MAX_REGIONS)
                                err = rds_pkg::ST_SEPARATION;
                        end
                    end
                    default:
                    begin
                        if (c == rds_pkg::CH_AMP)
                        begin
                            conn_pend = rds_pkg::CONN_AND;
                            ph = SCAN_MUST;
                        end
                        else if (c == rds_pkg::CH_BAR)
                        begin
                            conn_pend = rds_pkg::CONN_OR;
                            ph = SCAN_MUST;
                        end
                        else if (c == rds_pkg::CH_SEMI)
                            ph = SCAN_FRESH;
                    end
                endcase
            end
            if (pos < rds_pkg::LINE_LENGTH)
                pos++;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        rds_pkg::rds_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (beats_due.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                e = beats_due.pop_front();
                check_field("kind", e.kind, kind);
                check_field("region_index", e.region_index, region_index);
                check_field("region_type", e.region_type, region_type);
                check_field("exclude_flag", e.exclude_flag, exclude_flag);
                check_field("negate_flag", e.negate_flag, negate_flag);
                check_field("connector", e.connector, connector);
                check_field("param_start", e.param_start, param_start);
                check_field("status", e.status, status);
                check_field("region_count", e.region_count, region_count);
            end
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // valid is left high after a beat; the next call either reloads it or drops it
    task automatic send_beat(input logic [7:0] c, input logic eol);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_line <= eol;
        do @(posedge clk); while (!in_ready);
        track_line_char(c, eol);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_eol();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_eol();
    endtask

    task automatic test_shapes();
        send_line("circle 100 100 20");
        send_line("-!an 1 2 & AR 3 | b 4 ; c 5 ; E 6 ; pi 7 ; Poi 8 ; poL 9 ; t 10");
        send_line(" polygon 1 2 3 4 & !-text 1 2 x - ! ;");
        send_line("ANNULUS ARROW BOX");
        send_eol();
        send_line("box ");
    endtask

    task automatic test_bad_names();
        send_line("a 1");
        send_line("po 1");
        send_line("boxes 1");
        send_line("polygonpolygonpolygon 1");
        send_line("; box 1");
        send_line("& box 1");
        send_line("| box 1");
        // zero and high bytes are plain name characters
        send_beat(8'h00, 1'b0);
        send_line(" box 1");
        send_beat(8'hFF, 1'b0);
        send_line(" box 1");
        // just outside the lower-case range
        send_line("{ 1");
        send_line("`ox 1");
        send_line("xx 1 & box 2");
    endtask

    task automatic test_line_ends();
        send_line("box");
        send_line("-");
        send_line("!");
        send_line("box 1 &");
        send_line("box 1 |");
        send_line("box 1 ;");
    endtask

    task automatic test_region_limit();
        string s;
        s = "";
        for (int i = 0; i < rds_pkg::MAX_REGIONS - 1; i++)
            s = {s, "b ; "};
        send_line(s);
        send_line({s, "-c 1 & t 2"});
    endtask

    // the second record lands just below the position limit, the third past it
    task automatic test_long_line();
        send_text("box 1");
        for (int i = 0; i < rds_pkg::LINE_LENGTH - 16; i++)
            send_beat($urandom_range(0, 1) ? "1" : ",", 1'b0);
        send_line(" & circle 2 | t 3");
    endtask

    task automatic send_random_line();
        string s;
        string pool;
        int roll;
        int n_regions;
        int shape;
        int len;
        int cut;
        int bad_at;
        logic [7:0] c;
        roll = $urandom_range(0, 19);
        if (roll < 2)
        begin
            // noise
            pool = " -!&|;aAbBpPoOtTx";
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 1))
                    c = 8'($urandom_range(0, 255));
                else
                    c = pool[$urandom_range(0, pool.len() - 1)];
                send_beat(c, 1'b0);
            end
            send_eol();
        end
        else
        begin
            n_regions = (roll == 2) ? $urandom_range(14, 17) : $urandom_range(1, 4);
            pool = "0123456789.,()-!#*";
            s = "";
            for (int r = 0; r < n_regions; r++)
            begin
                if (r > 0)
                begin
                    case ($urandom_range(0, 2))
                        0: s = {s, " & "};
                        1: s = {s, " | "};
                        default: s = {s, $urandom_range(0, 1) ? " ; " : ";"};
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    s = {s, "-"};
                if ($urandom_range(0, 3) == 0)
                    s = {s, $urandom_range(0, 1) ? "!" : " ! "};
                shape = $urandom_range(0, rds_pkg::SHAPE_COUNT - 1);
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, shape_txt[shape].len());
                else
                    len = $urandom_range(unique_len[shape], shape_txt[shape].len());
                for (int k = 0; k < len; k++)
                begin
                    c = shape_txt[shape][k];
                    if ($urandom_range(0, 1))
                        c = c + 8'd32;
                    s = {s, $sformatf("%c", c)};
                end
                if ($urandom_range(0, 15) == 0)
                    s = {s, "q"};
                s = {s, " "};
                for (int p = $urandom_range(0, 3); p > 0; p--)
                begin
                    for (int d = $urandom_range(1, 3); d > 0; d--)
                        s = {s, $sformatf("%c", pool[$urandom_range(0, pool.len() - 1)])};
                    s = {s, " "};
                end
            end
            cut = s.len();
            bad_at = -1;
            if ($urandom_range(0, 7) == 0)
                cut = $urandom_range(0, s.len());
            if ($urandom_range(0, 7) == 0)
                bad_at = $urandom_range(0, s.len() - 1);
            for (int i = 0; i < cut; i++)
                send_beat((i == bad_at) ? 8'($urandom_range(0, 255)) : s[i], 1'b0);
            send_eol();
        end
    endtask

    task automatic test_random_lines();
        int stop_at;
        stop_at = sent + RANDOM_ITEMS;
        while (sent < stop_at)
            send_random_line();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        quiet = 1'b1;
        stop_at = sent + STEADY_ITEMS;
        while (sent < stop_at)
            send_random_line();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = '0;
        end_of_line = 1'b0;
        clear_line_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_shapes();
        test_bad_names();
        test_line_ends();
        test_region_limit();
        test_long_line();
        test_random_lines();
        test_steady_stream();

        @(negedge clk);
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rds_pkg.sv
src/rds_name_match.sv
src/rds_scanner.sv
src/region_descriptor_splitter.sv
tb/tb_top.sv
